// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the lock table rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rrlt_pkg.sv -----
// ----------------------------------------------------------------------------
// rrlt_pkg
// types and constants of the rectangle region lock table
// ----------------------------------------------------------------------------
package rrlt_pkg;

  localparam int OWNER_W  = 8;
  localparam int ID_W     = 16;
  localparam int COORD_W  = 16;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);
  localparam logic [ID_W-1:0] LAST_ID  = '1;

  typedef struct packed {
    logic               op;
    logic [OWNER_W-1:0] owner;
    logic               write_mode;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [ID_W-1:0]    unlock_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_id;
  } rsp_t;

  typedef enum logic {
    CMD_LOCK,
    CMD_UNLOCK
  } cmd_kind_t;

  // classified request, box edges already summed
  typedef struct packed {
    cmd_kind_t          kind;
    logic [OWNER_W-1:0] owner;
    logic               wr;
    logic [COORD_W-1:0] x;
    logic [EDGE_W-1:0]  x_end;
    logic [COORD_W-1:0] y;
    logic [EDGE_W-1:0]  y_end;
    logic [ID_W-1:0]    id;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    id;
    logic               wr;
    logic [COORD_W-1:0] x;
    logic [EDGE_W-1:0]  x_end;
    logic [COORD_W-1:0] y;
    logic [EDGE_W-1:0]  y_end;
  } entry_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_TAIL,
    B_COMMIT
  } back_state_t;

endpackage

// ----- src/rrlt_ram.sv -----
// ----------------------------------------------------------------------------
// rrlt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rrlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rrlt_fifo.sv -----
// ----------------------------------------------------------------------------
// rrlt_fifo
// small register queue between the parts of the lock table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst, wr_en, !full || rd_en, "item written to a full queue")
  `ASSERT_IMPL(a_no_underflow, clk, rst, rd_en, !empty, "item read from an empty queue")

endmodule

// ----- src/rrlt_front.sv -----
// ----------------------------------------------------------------------------
// rrlt_front
// takes requests, classifies them and sums the box edges
// ----------------------------------------------------------------------------
module rrlt_front import rrlt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  input  logic hold,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_data
);

  logic stage_valid;
  logic stage_valid_next;
  cmd_t stage;
  cmd_t cmd_next;
  logic accept;

  assign full   = hold || (stage_valid && q_full);
  assign accept = push && !full;
  assign q_push = stage_valid && !q_full;
  assign q_data = stage;

  always_comb begin
    cmd_next.kind  = (req.op == OP_UNLOCK) ? CMD_UNLOCK : CMD_LOCK;
    cmd_next.owner = req.owner;
    cmd_next.wr    = req.write_mode;
    cmd_next.x     = req.rect_x;
    cmd_next.x_end = {1'b0, req.rect_x} + {1'b0, req.rect_w};
    cmd_next.y     = req.rect_y;
    cmd_next.y_end = {1'b0, req.rect_y} + {1'b0, req.rect_h};
    cmd_next.id    = req.unlock_id;
    stage_valid_next = accept || (stage_valid && q_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= cmd_next;
    end
  end

endmodule

// ----- src/rrlt_back.sv -----
// ----------------------------------------------------------------------------
// rrlt_back
// sweeps the entry table for each request and writes back the outcome
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrlt_back import rrlt_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd_in,
  output logic cmd_pop,
  output logic res_push,
  output rsp_t res_data,
  input  logic res_full,
  output logic clearing
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int EW   = $bits(entry_t);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  back_state_t       state;
  back_state_t       state_next;
  logic [IDXW-1:0]   idx;
  logic [IDXW-1:0]   idx_next;
  cmd_t              cmd;
  logic              chk_valid;
  logic [IDXW-1:0]   chk_idx;
  logic              conflict;
  logic              found;
  logic [IDXW-1:0]   slot;
  logic [ID_W-1:0]   next_id;

  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic              ram_re;
  logic [EW-1:0]     ram_rdata;
  entry_t            rd_entry;
  entry_t            new_entry;

  logic              is_lock;
  logic              grant;
  logic              commit_write;
  logic              meet;
  logic              lock_hit;
  logic              unlock_hit;

  rrlt_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign clearing = (state == B_CLEAR);

  // overlap of closed boxes and hit tests on the entry just read
  always_comb begin
    meet = ({1'b0, rd_entry.x} <= cmd.x_end) && ({1'b0, cmd.x} <= rd_entry.x_end) &&
           ({1'b0, rd_entry.y} <= cmd.y_end) && ({1'b0, cmd.y} <= rd_entry.y_end);
    lock_hit   = rd_entry.valid && (cmd.wr || rd_entry.wr) && meet;
    unlock_hit = rd_entry.valid && (rd_entry.owner == cmd.owner) && (rd_entry.id == cmd.id);
  end

  // outcome of the finished sweep
  always_comb begin
    is_lock      = (cmd.kind == CMD_LOCK);
    grant        = is_lock && !conflict && found;
    commit_write = found && !(is_lock && conflict);
    if (is_lock) begin
      if (conflict) begin
        res_data.status = ST_CONFLICT;
      end else if (found) begin
        res_data.status = ST_OK;
      end else begin
        res_data.status = ST_FULL;
      end
    end else begin
      res_data.status = found ? ST_OK : ST_MISSING;
    end
    res_data.granted_id = grant ? next_id : '0;
    new_entry.valid = is_lock;
    new_entry.owner = cmd.owner;
    new_entry.id    = next_id;
    new_entry.wr    = cmd.wr;
    new_entry.x     = cmd.x;
    new_entry.x_end = cmd.x_end;
    new_entry.y     = cmd.y;
    new_entry.y_end = cmd.y_end;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd_pop    = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = '0;
    res_push   = 1'b0;
    unique case (state)
      B_CLEAR: begin
        ram_we = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = B_IDLE;
        end else begin
          idx_next = idx + IDXW'(1);
        end
      end
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          idx_next   = '0;
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        ram_re = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = B_TAIL;
        end else begin
          idx_next = idx + IDXW'(1);
        end
      end
      B_TAIL: begin
        state_next = B_COMMIT;
      end
      B_COMMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          ram_we     = commit_write;
          ram_waddr  = slot;
          ram_wdata  = new_entry;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      idx       <= '0;
      chk_valid <= 1'b0;
      conflict  <= 1'b0;
      found     <= 1'b0;
      slot      <= '0;
      next_id   <= FIRST_ID;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      chk_valid <= (state == B_SCAN);
      if (cmd_pop) begin
        conflict <= 1'b0;
        found    <= 1'b0;
        slot     <= '0;
      end else if (chk_valid) begin
        if (is_lock) begin
          if (lock_hit) begin
            conflict <= 1'b1;
          end
          if (!rd_entry.valid && !found) begin
            found <= 1'b1;
            slot  <= chk_idx;
          end
        end else if (unlock_hit && !found) begin
          found <= 1'b1;
          slot  <= chk_idx;
        end
      end
      if (res_push && grant) begin
        next_id <= (next_id == LAST_ID) ? FIRST_ID : next_id + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (cmd_pop) begin
      cmd <= cmd_in;
    end
  end

  `ASSERT_IMPL(a_wr_phase, clk, rst, ram_we, (state == B_CLEAR) || (state == B_COMMIT), "table written outside clear or commit")
  `ASSERT_NEXT(a_sweep_end, clk, rst, (state == B_SCAN) && (idx == LAST_IDX), state == B_TAIL, "sweep did not end at last entry")
  `ASSERT_IMPL(a_id_nonzero, clk, rst, 1'b1, next_id != '0, "lock id counter reached zero")

endmodule

// ----- src/rectangle_region_lock_table.sv -----
// ----------------------------------------------------------------------------
// rectangle_region_lock_table
// reader/writer lock table over rectangles, queue interfaces on both sides
// ----------------------------------------------------------------------------
// Each request gives exactly one result. The table engine handles one item
// at a time: it takes the item from the request queue, sweeps the entry
// memory for conflicts, free slots or the matching lock, waits for the last
// read, and then posts the result, writing the entry back when the request
// succeeds, once the result queue has room. A register and a two-item
// queue in front and a two-item queue behind let requests and results move
// while the engine is busy. After reset the engine clears the entry memory,
// and full stays high until it is done.
module rectangle_region_lock_table import rrlt_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RSP_W = $bits(rsp_t);

  logic             hold;
  logic             q_full;
  logic             q_push;
  cmd_t             q_data;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;
  logic             cmd_pop;
  logic             res_push;
  rsp_t             res_data;
  logic             res_full;
  logic [RSP_W-1:0] rsp_rdata;

  rrlt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req    (req),
    .hold   (hold),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  rrlt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_data),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  rrlt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd_in    (cmd_t'(q_rdata)),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .clearing  (hold)
  );

  rrlt_fifo #(
    .WIDTH (RSP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_rsp_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (rsp_rdata),
    .empty   (empty)
  );

  assign rsp = rsp_t'(rsp_rdata);

endmodule
